@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define GAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define GAS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/gas_pkg.sv @@
// Shared types and constants of the graph adjacency store.
`default_nettype none

package gas_pkg;

   localparam int VERTEX_W = 6;
   localparam int OP_W     = 3;
   localparam int IN_WT_W  = 16;
   localparam int CSR_W    = 7;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 32;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR      = 3'd0,
      OP_ADD_VERTEX = 3'd1,
      OP_DEL_VERTEX = 3'd2,
      OP_ADD_EDGE   = 3'd3,
      OP_DEL_EDGE   = 3'd4,
      OP_SUCC       = 3'd5,
      OP_PRED       = 3'd6,
      OP_ADJ        = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_SPARE   = 2'd3
   } status_type;

   localparam logic CSR_DIRECTED  = 1'b0;
   localparam logic CSR_INIT_VERT = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_APP2,
      S_RD,
      S_EV,
      S_SCAN_END,
      S_FIN
   } state_type;

   typedef struct packed {
      logic accept;
      logic dispatch;
      logic app2;
      logic rd;
      logic ev;
      logic scan_end;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic scan_start;
      logic go_app2;
      logic etotal_zero;
      logic ev_stall;
      logic scan_done;
      logic more_v;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/core/gas_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module gas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/gas_ctrl.sv @@
// Sequencing state machine of the graph adjacency store.
`default_nettype none

module gas_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire gas_pkg::sts_type sts,
   output gas_pkg::cmd_type     cmd
);

   gas_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gas_pkg::S_IDLE: begin
            if (req_tvalid) state_in = gas_pkg::S_DISPATCH;
         end
         gas_pkg::S_DISPATCH: begin
            if (sts.go_app2) state_in = gas_pkg::S_APP2;
            else if (sts.scan_start)
               state_in = sts.etotal_zero ? gas_pkg::S_SCAN_END : gas_pkg::S_RD;
            else state_in = gas_pkg::S_FIN;
         end
         gas_pkg::S_APP2: state_in = gas_pkg::S_FIN;
         gas_pkg::S_RD:   state_in = gas_pkg::S_EV;
         gas_pkg::S_EV: begin
            if (!sts.ev_stall)
               state_in = sts.scan_done ? gas_pkg::S_SCAN_END : gas_pkg::S_RD;
         end
         gas_pkg::S_SCAN_END: begin
            if (sts.more_v)
               state_in = sts.etotal_zero ? gas_pkg::S_SCAN_END : gas_pkg::S_RD;
            else state_in = gas_pkg::S_FIN;
         end
         gas_pkg::S_FIN: begin
            if (sts.rsp_free) state_in = gas_pkg::S_IDLE;
         end
         default: state_in = gas_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         gas_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         gas_pkg::S_DISPATCH: cmd.dispatch = 1'b1;
         gas_pkg::S_APP2:     cmd.app2 = 1'b1;
         gas_pkg::S_RD:       cmd.rd = 1'b1;
         gas_pkg::S_EV:       cmd.ev = 1'b1;
         gas_pkg::S_SCAN_END: cmd.scan_end = 1'b1;
         gas_pkg::S_FIN:      cmd.fin = sts.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gas_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/gas_dp.sv @@
// Datapath of the graph adjacency store: edge table, counters, result registers.
`default_nettype none

module gas_dp #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [gas_pkg::REQ_W-1:0]   req_tdata,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [gas_pkg::CSR_W-1:0]   csr_wdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [gas_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tlast,
   input  wire gas_pkg::cmd_type            cmd,
   output gas_pkg::sts_type                 sts
);

   localparam int VW      = gas_pkg::VERTEX_W;
   localparam int EAW     = $clog2(MAX_EDGES);
   localparam int ECW     = $clog2(MAX_EDGES + 1);
   localparam int VCW     = $clog2(MAX_VERTICES + 1);
   localparam int CMPW    = (VCW > VW) ? VCW : VW;
   localparam int INW     = (VCW > gas_pkg::CSR_W) ? VCW : gas_pkg::CSR_W;
   localparam int ENTRY_W = 2 * VW + WEIGHT_BITS;

   gas_pkg::op_type            op_ff, op_in;
   logic [VW-1:0]              a_ff, a_in, b_ff, b_in;
   logic signed [15:0]         w_ff, w_in;
   logic                       dir_ff, dir_in;
   logic [gas_pkg::CSR_W-1:0]  init_ff, init_in;
   logic [VCW-1:0]             vcount_ff, vcount_in, vscan_ff, vscan_in;
   logic [ECW-1:0]             etotal_ff, etotal_in, idx_ff, idx_in, wr_ff, wr_in;
   logic                       pend_valid_ff, pend_valid_in;
   gas_pkg::status_type        pend_status_ff, pend_status_in;
   logic [VW-1:0]              pend_nb_ff, pend_nb_in;
   logic signed [15:0]         pend_w_ff, pend_w_in;
   logic                       pend_adj_ff, pend_adj_in, pend_empty_ff, pend_empty_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   gas_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [VW-1:0]              rsp_nb_ff, rsp_nb_in;
   logic signed [15:0]         rsp_w_ff, rsp_w_in;
   logic                       rsp_adj_ff, rsp_adj_in, rsp_empty_ff, rsp_empty_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       ram_we;
   logic [EAW-1:0]             ram_waddr;
   logic [ENTRY_W-1:0]         ram_wdata, ram_rdata;
   logic [VW-1:0]              rd_s, rd_t, new_s, new_t;
   logic signed [WEIGHT_BITS-1:0] rd_w, w_store;
   logic signed [15:0]         rd_w16;

   logic a_bad, b_bad, vfull, efull, list_op, match, drop, rsp_free, ev_go, push_mid;

   gas_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EDGES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.rd),
      .raddr (idx_ff[EAW-1:0]),
      .rdata (ram_rdata)
   );

   assign rd_s    = ram_rdata[VW-1:0];
   assign rd_t    = ram_rdata[2*VW-1:VW];
   assign rd_w    = ram_rdata[ENTRY_W-1:2*VW];
   assign rd_w16  = 16'(rd_w);
   assign w_store = WEIGHT_BITS'(w_ff);
   assign new_s   = (rd_s > a_ff) ? rd_s - 1'b1 : rd_s;
   assign new_t   = (rd_t > a_ff) ? rd_t - 1'b1 : rd_t;

   assign a_bad   = CMPW'(a_ff) >= CMPW'(vcount_ff);
   assign b_bad   = CMPW'(b_ff) >= CMPW'(vcount_ff);
   assign vfull   = vcount_ff == VCW'(MAX_VERTICES);
   assign efull   = ((ECW+1)'(etotal_ff) + (dir_ff ? (ECW+1)'(1) : (ECW+1)'(2)))
                    > (ECW+1)'(MAX_EDGES);
   assign list_op = (op_ff == gas_pkg::OP_SUCC) || (op_ff == gas_pkg::OP_PRED);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      match = 1'b0;
      drop  = 1'b0;
      case (op_ff)
         gas_pkg::OP_SUCC: match = rd_s == a_ff;
         gas_pkg::OP_PRED: match = (CMPW'(rd_s) == CMPW'(vscan_ff)) && (rd_t == a_ff);
         gas_pkg::OP_ADJ:  match = (rd_s == a_ff) && (rd_t == b_ff);
         gas_pkg::OP_DEL_VERTEX: drop = (rd_s == a_ff) || (rd_t == a_ff);
         gas_pkg::OP_DEL_EDGE:
            drop = ((rd_s == a_ff) && (rd_t == b_ff)) ||
                   (!dir_ff && (rd_s == b_ff) && (rd_t == a_ff));
         default: ;
      endcase
   end

   assign push_mid = list_op && match && pend_valid_ff;
   assign ev_go    = cmd.ev && !(push_mid && !rsp_free);

   always_comb begin
      sts = '0;
      sts.scan_start = (op_ff == gas_pkg::OP_DEL_VERTEX && !a_bad) ||
                       (op_ff == gas_pkg::OP_DEL_EDGE && !a_bad && !b_bad) ||
                       (op_ff == gas_pkg::OP_ADJ && !a_bad && !b_bad) ||
                       (list_op && !a_bad);
      sts.go_app2     = op_ff == gas_pkg::OP_ADD_EDGE && !a_bad && !b_bad && !efull && !dir_ff;
      sts.etotal_zero = etotal_ff == '0;
      sts.ev_stall    = push_mid && !rsp_free;
      sts.scan_done   = idx_ff == etotal_ff;
      sts.more_v      = (op_ff == gas_pkg::OP_PRED) &&
                        ((VCW+1)'(vscan_ff) + (VCW+1)'(1) < (VCW+1)'(vcount_ff));
      sts.rsp_free    = rsp_free;
   end

   always_comb begin
      op_in = op_ff;  a_in = a_ff;  b_in = b_ff;  w_in = w_ff;
      dir_in = dir_ff;  init_in = init_ff;
      vcount_in = vcount_ff;  etotal_in = etotal_ff;
      idx_in = idx_ff;  wr_in = wr_ff;  vscan_in = vscan_ff;
      pend_valid_in = pend_valid_ff;  pend_status_in = pend_status_ff;
      pend_nb_in = pend_nb_ff;  pend_w_in = pend_w_ff;
      pend_adj_in = pend_adj_ff;  pend_empty_in = pend_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;  rsp_nb_in = rsp_nb_ff;  rsp_w_in = rsp_w_ff;
      rsp_adj_in = rsp_adj_ff;  rsp_empty_in = rsp_empty_ff;  rsp_last_in = rsp_last_ff;
      ram_we = 1'b0;
      ram_waddr = etotal_ff[EAW-1:0];
      ram_wdata = {w_store, b_ff, a_ff};

      if (csr_we) begin
         case (csr_index)
            gas_pkg::CSR_DIRECTED:  dir_in  = csr_wdata[0];
            gas_pkg::CSR_INIT_VERT: init_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         op_in = gas_pkg::op_type'(req_tdata[2:0]);
         a_in  = req_tdata[8:3];
         b_in  = req_tdata[14:9];
         w_in  = req_tdata[30:15];
      end

      if (cmd.dispatch) begin
         pend_valid_in  = 1'b1;
         pend_status_in = gas_pkg::STAT_OK;
         pend_nb_in = '0;  pend_w_in = '0;  pend_adj_in = 1'b0;  pend_empty_in = 1'b0;
         idx_in = '0;  wr_in = '0;  vscan_in = '0;
         case (op_ff)
            gas_pkg::OP_CLEAR: begin
               etotal_in = '0;
               vcount_in = (INW'(init_ff) > INW'(MAX_VERTICES)) ?
                           VCW'(MAX_VERTICES) : VCW'(init_ff);
            end
            gas_pkg::OP_ADD_VERTEX: begin
               if (vfull) pend_status_in = gas_pkg::STAT_FULL;
               else begin
                  vcount_in  = vcount_ff + 1'b1;
                  pend_nb_in = VW'(vcount_ff);
               end
            end
            gas_pkg::OP_ADD_EDGE: begin
               if (a_bad || b_bad) pend_status_in = gas_pkg::STAT_INVALID;
               else if (efull) pend_status_in = gas_pkg::STAT_FULL;
               else begin
                  ram_we    = 1'b1;
                  etotal_in = etotal_ff + 1'b1;
               end
            end
            gas_pkg::OP_DEL_EDGE, gas_pkg::OP_ADJ: begin
               if (a_bad || b_bad) pend_status_in = gas_pkg::STAT_INVALID;
            end
            default: begin
               if (a_bad) pend_status_in = gas_pkg::STAT_INVALID;
               else if (list_op) pend_valid_in = 1'b0;
            end
         endcase
      end

      if (cmd.app2) begin
         ram_we    = 1'b1;
         ram_wdata = {w_store, a_ff, b_ff};
         etotal_in = etotal_ff + 1'b1;
      end

      if (cmd.rd) idx_in = idx_ff + 1'b1;

      if (ev_go) begin
         if (op_ff == gas_pkg::OP_DEL_VERTEX || op_ff == gas_pkg::OP_DEL_EDGE) begin
            if (!drop) begin
               ram_we    = 1'b1;
               ram_waddr = wr_ff[EAW-1:0];
               ram_wdata = (op_ff == gas_pkg::OP_DEL_VERTEX) ? {rd_w, new_t, new_s}
                                                             : ram_rdata;
               wr_in     = wr_ff + 1'b1;
            end
         end else if (op_ff == gas_pkg::OP_ADJ) begin
            if (match) pend_adj_in = 1'b1;
         end else if (list_op && match) begin
            if (pend_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;  rsp_nb_in = pend_nb_ff;
               rsp_w_in = pend_w_ff;  rsp_adj_in = pend_adj_ff;
               rsp_empty_in = pend_empty_ff;  rsp_last_in = 1'b0;
            end
            pend_valid_in  = 1'b1;
            pend_status_in = gas_pkg::STAT_OK;
            pend_nb_in     = (op_ff == gas_pkg::OP_SUCC) ? rd_t : VW'(vscan_ff);
            pend_w_in      = rd_w16;
         end
      end

      if (cmd.scan_end) begin
         if (op_ff == gas_pkg::OP_DEL_VERTEX || op_ff == gas_pkg::OP_DEL_EDGE)
            etotal_in = wr_ff;
         if (op_ff == gas_pkg::OP_DEL_VERTEX) vcount_in = vcount_ff - 1'b1;
         if (sts.more_v) begin
            vscan_in = vscan_ff + 1'b1;
            idx_in   = '0;
         end else if (list_op && !pend_valid_ff) begin
            pend_valid_in = 1'b1;
            pend_empty_in = 1'b1;
         end
      end

      if (cmd.fin) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;  rsp_nb_in = pend_nb_ff;
         rsp_w_in = pend_w_ff;  rsp_adj_in = pend_adj_ff;
         rsp_empty_in = pend_empty_ff;  rsp_last_in = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= 1'b0;
         init_ff       <= '0;
         vcount_ff     <= '0;
         etotal_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dir_ff        <= dir_in;
         init_ff       <= init_in;
         vcount_ff     <= vcount_in;
         etotal_ff     <= etotal_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  a_ff <= a_in;  b_ff <= b_in;  w_ff <= w_in;
      idx_ff <= idx_in;  wr_ff <= wr_in;  vscan_ff <= vscan_in;
      pend_status_ff <= pend_status_in;  pend_nb_ff <= pend_nb_in;
      pend_w_ff <= pend_w_in;  pend_adj_ff <= pend_adj_in;  pend_empty_ff <= pend_empty_in;
      rsp_status_ff <= rsp_status_in;  rsp_nb_ff <= rsp_nb_in;  rsp_w_ff <= rsp_w_in;
      rsp_adj_ff <= rsp_adj_in;  rsp_empty_ff <= rsp_empty_in;  rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_empty_ff, rsp_adj_ff, rsp_w_ff, rsp_nb_ff, rsp_status_ff};

endmodule

`default_nettype wire

@@ rtl/core/graph_adjacency_store_core.sv @@
// Top level of the graph adjacency store.
`default_nettype none

// Weighted graph store holding its edges as one table in insertion order, in a
// single RAM of MAX_EDGES entries. One request is worked on at a time, and the
// next request is taken as soon as the previous one has finished, even while
// its last response still waits in the output register. Add edge writes a
// second, reversed entry when the store is undirected. Remove vertex, remove
// edge, successors and the adjacency test scan the live table entry by entry,
// and predecessors repeat that scan once for every vertex. The scans read the
// table through its one RAM read port, and a list scan waits whenever a match
// finds the response register still full. A list query streams one response
// per match with tlast on the final one, or a single response with empty_res
// set when nothing matched. Configuration writes are taken at any time but
// should be made only while the block is idle.

module graph_adjacency_store_core #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request: op [2:0], vertex_a [8:3], vertex_b [14:9], edge_weight [30:15].
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [gas_pkg::REQ_W-1:0] req_tdata,
   // Response: status [1:0], neighbour [7:2], neighbour_weight [23:8],
   // is_adjacent [24], empty_res [25].
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [gas_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                           rsp_tlast,
   // Register 0 is directed, register 1 is initial_vertices.
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [gas_pkg::CSR_W-1:0] csr_wdata
);

   gas_pkg::cmd_type cmd;
   gas_pkg::sts_type sts;

   // The controller only sequences; all decisions on the table data are made
   // in the datapath and reported back as status.
   gas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gas_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

@@ rtl/core/gas_checker.sv @@
// Port-level checker of the graph adjacency store and its bind.
`default_nettype none
`include "assert_macros.svh"

module gas_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic [gas_pkg::RSP_W-1:0] rsp_tdata,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic                      rsp_tlast
);

   logic                    rsp_stall;
   logic                    req_take;
   logic                    rsp_mid;
   logic                    mid_clean;
   logic [gas_pkg::RSP_W:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_take  = req_tvalid && req_tready;
   assign rsp_mid   = rsp_tvalid && !rsp_tlast;
   assign mid_clean = (rsp_tdata[1:0] == gas_pkg::STAT_OK) && !rsp_tdata[25] && !rsp_tdata[24];
   assign rsp_word  = {rsp_tlast, rsp_tdata};

   // A stalled response keeps its content.
   `GAS_ASSERT(a_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_word), "stall broken")

   // Reset leaves no response pending.
   `GAS_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "response valid after reset")

   // One request at a time: a new request is never taken in the cycle after one.
   `GAS_ASSERT(a_one_req, clock, reset, req_take |=> !req_tready, "back to back request accepted")

   // Only list matches stream without tlast, and they are always ok and non-empty.
   `GAS_ASSERT(a_mid_ok, clock, reset, rsp_mid |-> mid_clean, "bad intermediate response")

endmodule

bind graph_adjacency_store_core gas_checker u_gas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ tb/graph_adjacency_store_core_tb.sv @@
// Self-checking testbench for the graph adjacency store core.
`default_nettype none

module graph_adjacency_store_core_tb;
   import gas_pkg::*;

   localparam int NV = 64;
   localparam int NE = 64;

   // One request as the driver sends it.
   typedef struct packed {
      logic [15:0] weight;
      logic [5:0]  vb;
      logic [5:0]  va;
      op_type      op;
   } request_t;

   // One response with every field the block reports.
   typedef struct packed {
      status_type  status;
      logic [5:0]  nbr;
      logic [15:0] nbr_weight;
      logic        adjacent;
      logic        empty;
      logic        last;
   } response_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   graph_adjacency_store_core i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_we, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   // Shadow copy of the graph, updated as each request is accepted.
   logic [5:0]  gr_src [NE];
   logic [5:0]  gr_dst [NE];
   logic [15:0] gr_wt  [NE];
   int          gr_edges = 0;
   int          gr_vertices = 0;
   logic        gr_directed = 1'b0;
   logic [6:0]  gr_init_vertices = '0;

   request_t  pending_requests[$];
   response_t expected_responses[$];
   int        errors = 0;
   bit        stimulus_done = 1'b0;
   int        hold_off = 0;

   // Queue helpers for the expected responses and the pending requests.
   function automatic void expect_response(response_t r);
      expected_responses = {expected_responses, r};
   endfunction

   function automatic void queue_request(request_t rq);
      pending_requests = {pending_requests, rq};
   endfunction

   function automatic response_t single(status_type st, logic [5:0] nb, logic adj);
      response_t r;
      r = '0;
      r.status = st;
      r.nbr = nb;
      r.adjacent = adj;
      r.last = 1'b1;
      return r;
   endfunction

   // Keep the table packed, dropping entries that match; optionally renumber
   // vertices above the removed one.
   function automatic void compact_edges(bit drop_vertex, int a, int b);
      int j;
      int s;
      int t;
      bit drop;
      j = 0;
      for (int i = 0; i < gr_edges; i++) begin
         s = gr_src[i];
         t = gr_dst[i];
         if (drop_vertex) drop = (s == a) || (t == a);
         else drop = (s == a && t == b) || (!gr_directed && s == b && t == a);
         if (!drop) begin
            if (drop_vertex && s > a) s--;
            if (drop_vertex && t > a) t--;
            gr_src[j] = s[5:0];
            gr_dst[j] = t[5:0];
            gr_wt[j] = gr_wt[i];
            j++;
         end
      end
      gr_edges = j;
   endfunction

   function automatic void append_edge(int s, int t, logic [15:0] w);
      gr_src[gr_edges] = s[5:0];
      gr_dst[gr_edges] = t[5:0];
      gr_wt[gr_edges] = w;
      gr_edges++;
   endfunction

   // Apply one request to the shadow graph and queue the responses it causes.
   function automatic void apply_graph_request(request_t rq);
      int a;
      int b;
      int first;
      bit hit;
      response_t r;
      a = rq.va;
      b = rq.vb;
      first = expected_responses.size();
      hit = 1'b0;
      case (rq.op)
         OP_CLEAR: begin
            gr_vertices = (gr_init_vertices > NV) ? NV : gr_init_vertices;
            gr_edges = 0;
            expect_response(single(STAT_OK, '0, 1'b0));
         end
         OP_ADD_VERTEX: begin
            if (gr_vertices >= NV) begin
               expect_response(single(STAT_FULL, '0, 1'b0));
            end else begin
               expect_response(single(STAT_OK, gr_vertices[5:0], 1'b0));
               gr_vertices++;
            end
         end
         OP_DEL_VERTEX: begin
            if (a >= gr_vertices) begin
               expect_response(single(STAT_INVALID, '0, 1'b0));
            end else begin
               compact_edges(1'b1, a, 0);
               gr_vertices--;
               expect_response(single(STAT_OK, '0, 1'b0));
            end
         end
         OP_ADD_EDGE: begin
            if (a >= gr_vertices || b >= gr_vertices) begin
               expect_response(single(STAT_INVALID, '0, 1'b0));
            end else if (gr_edges + (gr_directed ? 1 : 2) > NE) begin
               expect_response(single(STAT_FULL, '0, 1'b0));
            end else begin
               append_edge(a, b, rq.weight);
               if (!gr_directed) append_edge(b, a, rq.weight);
               expect_response(single(STAT_OK, '0, 1'b0));
            end
         end
         OP_DEL_EDGE: begin
            if (a >= gr_vertices || b >= gr_vertices) begin
               expect_response(single(STAT_INVALID, '0, 1'b0));
            end else begin
               compact_edges(1'b0, a, b);
               expect_response(single(STAT_OK, '0, 1'b0));
            end
         end
         OP_SUCC, OP_PRED: begin
            if (a >= gr_vertices) begin
               expect_response(single(STAT_INVALID, '0, 1'b0));
            end else begin
               r = '0;
               if (rq.op == OP_SUCC) begin
                  for (int i = 0; i < gr_edges; i++)
                     if (gr_src[i] == a) begin
                        r.nbr = gr_dst[i];
                        r.nbr_weight = gr_wt[i];
                        expect_response(r);
                     end
               end else begin
                  // Ordered by source vertex, then by table position.
                  for (int v = 0; v < gr_vertices; v++)
                     for (int i = 0; i < gr_edges; i++)
                        if (gr_src[i] == v && gr_dst[i] == a) begin
                           r.nbr = v[5:0];
                           r.nbr_weight = gr_wt[i];
                           expect_response(r);
                        end
               end
               if (expected_responses.size() == first) begin
                  r = '0;
                  r.empty = 1'b1;
                  r.last = 1'b1;
                  expect_response(r);
               end else begin
                  expected_responses[expected_responses.size()-1].last = 1'b1;
               end
            end
         end
         default: begin
            if (a >= gr_vertices || b >= gr_vertices) begin
               expect_response(single(STAT_INVALID, '0, 1'b0));
            end else begin
               for (int i = 0; i < gr_edges; i++)
                  if (gr_src[i] == a && gr_dst[i] == b) hit = 1'b1;
               expect_response(single(STAT_OK, '0, hit));
            end
         end
      endcase
   endfunction

   // Driver: offers queued requests with random gaps between them.
   int drv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_graph_request(request_t'(req_tdata[30:0]));
            void'(pending_requests.pop_front());
            drv_gap = $urandom_range(0, 4);
         end
         if (drv_gap > 0 && !(req_tvalid && !req_tready)) begin
            drv_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {1'b0, pending_requests[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response against the oldest expectation, and stalls
   // at random or for a long stretch when a hold-off is requested.
   int mon_gap = 0;
   response_t got;
   response_t want;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[1:0]);
            got.nbr = rsp_tdata[7:2];
            got.nbr_weight = rsp_tdata[23:8];
            got.adjacent = rsp_tdata[24];
            got.empty = rsp_tdata[25];
            got.last = rsp_tlast;
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               if (got !== want) begin
                  $display("%0t: response mismatch, expected %p, actual %p",
                     $time, want, got);
                  errors++;
               end
            end
            mon_gap = $urandom_range(0, 4);
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (mon_gap > 0) begin
            mon_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic request_t make_request(op_type op, int a, int b, int w);
      request_t rq;
      rq.op = op;
      rq.va = a[5:0];
      rq.vb = b[5:0];
      rq.weight = w[15:0];
      return rq;
   endfunction

   // Pick a vertex that is usually valid, sometimes just out of range or wild.
   function automatic int pick_vertex(int count);
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return $urandom_range(0, 63);
      if (k == 1) return count;
      return (count > 0) ? $urandom_range(0, count - 1) : 0;
   endfunction

   task automatic wait_idle();
      while (pending_requests.size() > 0 || expected_responses.size() > 0)
         @(posedge clock);
      // The block may still be finishing internally after its last response.
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [6:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DIRECTED) gr_directed = value[0];
      else gr_init_vertices = value;
   endtask

   // Random phase: mostly meaningful graph work with some broken requests.
   task automatic random_phase(int n, int vmax);
      int k;
      int vc;
      for (int i = 0; i < n; i++) begin
         vc = gr_vertices;
         k = $urandom_range(0, 99);
         if (k < 2)
            queue_request(make_request(OP_CLEAR, 0, 0, 0));
         else if (k < 8 && vc < vmax)
            queue_request(make_request(OP_ADD_VERTEX, 0, 0, 0));
         else if (k < 12)
            queue_request(make_request(OP_DEL_VERTEX, pick_vertex(vc), 0, 0));
         else if (k < 45)
            queue_request(make_request(OP_ADD_EDGE, pick_vertex(vc),
               pick_vertex(vc), $urandom_range(0, 65535)));
         else if (k < 55)
            queue_request(make_request(OP_DEL_EDGE, pick_vertex(vc),
               pick_vertex(vc), $urandom_range(0, 65535)));
         else if (k < 70)
            queue_request(make_request(OP_SUCC, pick_vertex(vc),
               $urandom_range(0, 63), 0));
         else if (k < 80)
            queue_request(make_request(OP_PRED, pick_vertex(vc),
               $urandom_range(0, 63), 0));
         else
            queue_request(make_request(OP_ADJ, pick_vertex(vc),
               pick_vertex(vc), 0));
         // Track the vertex count roughly by draining one at a time.
         while (pending_requests.size() > 0) @(posedge clock);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // First part: undirected store with four vertices.
      write_register(CSR_INIT_VERT, 7'd4);
      write_register(CSR_DIRECTED, 1'b0);
      queue_request(make_request(OP_CLEAR, 0, 0, 0));
      queue_request(make_request(OP_ADD_EDGE, 0, 3, 16'h7fff));
      queue_request(make_request(OP_ADD_EDGE, 2, 2, 16'h8000));
      queue_request(make_request(OP_ADD_EDGE, 0, 3, 16'hffff));
      queue_request(make_request(OP_ADD_EDGE, 0, 4, 0));
      queue_request(make_request(OP_ADD_EDGE, 63, 1, 0));
      queue_request(make_request(OP_SUCC, 0, 0, 0));
      queue_request(make_request(OP_SUCC, 1, 0, 0));
      queue_request(make_request(OP_PRED, 3, 0, 0));
      queue_request(make_request(OP_PRED, 63, 0, 0));
      queue_request(make_request(OP_ADJ, 3, 0, 0));
      queue_request(make_request(OP_ADJ, 1, 2, 0));
      queue_request(make_request(OP_ADJ, 0, 63, 0));
      queue_request(make_request(OP_DEL_EDGE, 3, 0, 0));
      queue_request(make_request(OP_DEL_EDGE, 0, 42, 0));
      queue_request(make_request(OP_ADD_VERTEX, 0, 0, 0));
      queue_request(make_request(OP_DEL_VERTEX, 1, 0, 0));
      queue_request(make_request(OP_DEL_VERTEX, 60, 0, 0));
      queue_request(make_request(OP_SUCC, 1, 0, 0));
      wait_idle();

      // Fill the edge table to hit the full case; the receiver holds off for a
      // long stretch so the block backs up and stalls its input.
      write_register(CSR_DIRECTED, 1'b1);
      hold_off = 300;
      for (int i = 0; i < 66; i++)
         queue_request(make_request(OP_ADD_EDGE, i % 4, (i + 1) % 4,
            $urandom_range(0, 65535)));
      queue_request(make_request(OP_PRED, 1, 0, 0));
      wait_idle();

      // Vertex space full: start at the maximum count.
      write_register(CSR_INIT_VERT, 7'd64);
      queue_request(make_request(OP_CLEAR, 0, 0, 0));
      queue_request(make_request(OP_ADD_VERTEX, 0, 0, 0));
      queue_request(make_request(OP_ADD_EDGE, 63, 0, 5));
      queue_request(make_request(OP_SUCC, 63, 0, 0));
      queue_request(make_request(OP_PRED, 63, 0, 0));
      wait_idle();
      random_phase(60, 64);
      wait_idle();

      // Saturating count beyond the maximum, then an empty graph.
      write_register(CSR_INIT_VERT, 7'd127);
      queue_request(make_request(OP_CLEAR, 0, 0, 0));
      wait_idle();
      write_register(CSR_INIT_VERT, 7'd0);
      write_register(CSR_DIRECTED, 1'b0);
      queue_request(make_request(OP_CLEAR, 0, 0, 0));
      queue_request(make_request(OP_SUCC, 0, 0, 0));
      wait_idle();

      // Random phases over several settings with small graphs mostly.
      for (int p = 0; p < 4; p++) begin
         write_register(CSR_DIRECTED, p[0]);
         write_register(CSR_INIT_VERT, 7'($urandom_range(1, 10)));
         queue_request(make_request(OP_CLEAR, 0, 0, 0));
         random_phase(80, 12);
         wait_idle();
      end
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done);
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_responses.size() == 0)
         $display("graph_adjacency_store_core_tb: clean");
      else
         $display("graph_adjacency_store_core_tb: errors");
      $finish;
   end

   initial begin
      #200000000;
      $display("graph_adjacency_store_core_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
